FILE: design/dpa_pkg.sv
// shared constants, types and sizing functions for the decimal product to ascii block
package dpa_pkg;

   localparam int OPERAND_BITS_DEF = 32;
   localparam int FIELD_BITS       = 32;
   localparam int DIGIT_BITS       = 4;
   localparam int CHAR_BITS        = 6;
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

   // operation applied to every digit cell in the same cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_DABBLE,
      CELL_SHIFT
   } cell_op_type;

   // decimal digits of 2^prod_bits - 1, floor(n * log10(2)) + 1
   function automatic int num_digits(input int prod_bits);
      num_digits = ((prod_bits * 1233) >> 12) + 1;
   endfunction

endpackage

FILE: design/dpa_cell.sv
// one bcd digit cell of the double-dabble chain
module dpa_cell (
   input  logic                               clock,
   input  dpa_pkg::cell_op_type               op,
   input  logic                               carry_bit,
   input  logic [dpa_pkg::DIGIT_BITS-1:0]     lower_digit,
   output logic                               carry_out,
   output logic [dpa_pkg::DIGIT_BITS-1:0]     digit
);

   logic [dpa_pkg::DIGIT_BITS-1:0] digit_ff;
   logic [dpa_pkg::DIGIT_BITS-1:0] digit_in;
   logic [dpa_pkg::DIGIT_BITS-1:0] adj;

   always_comb begin
      // add three before the shift so the doubled digit carries at ten
      adj = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
      case (op)
         dpa_pkg::CELL_CLEAR:  digit_in = '0;
         dpa_pkg::CELL_DABBLE: digit_in = {adj[dpa_pkg::DIGIT_BITS-2:0], carry_bit};
         dpa_pkg::CELL_SHIFT:  digit_in = lower_digit;
         default:              digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign carry_out = adj[dpa_pkg::DIGIT_BITS-1];
   assign digit     = digit_ff;

endmodule

FILE: design/decimal_product_to_ascii_top.sv
// top level: operand multiply, digit cell chain and digit emit control
//
//  channel | ports        | tdata / tuser / tlast
//  --------+--------------+---------------------------------------------------
//  req     | req_t*       | tdata[31:0] multiplicand, tdata[63:32] multiplier
//  rsp     | rsp_t*       | tdata[5:0] digit_char, tdata[7:6] zero, tlast last_digit
//
// an item is multiplied into the product register on acceptance, shifted into the
// digit cell chain one product bit per cycle, then its leading zeros are dropped
// one digit position at a time and each remaining digit is handed to the output
// register, which waits while the result side stalls.
// reset is synchronous and clears the control state and the output valid.
// a stall on rsp holds the chain; a new item is taken once the last digit sits
// in the output register.
module decimal_product_to_ascii_top #(
   parameter int OPERAND_BITS = dpa_pkg::OPERAND_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // multiplicand [31:0], multiplier [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // digit_char [5:0], zero [7:6]
   output logic        rsp_tlast    // last_digit
);

   localparam int PROD_BITS  = 2 * OPERAND_BITS;
   localparam int NUM_DIGITS = dpa_pkg::num_digits(PROD_BITS);
   localparam int CNT_BITS   = $clog2(PROD_BITS);
   localparam int REM_BITS   = $clog2(NUM_DIGITS + 1);
   localparam int DB         = dpa_pkg::DIGIT_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DABBLE,
      ST_SKIP,
      ST_EMIT
   } state_type;

   state_type                      state_ff;
   logic [PROD_BITS-1:0]           product_ff;
   logic [CNT_BITS-1:0]            count_ff;
   logic [REM_BITS-1:0]            remaining_ff;
   logic                           rsp_valid_ff;
   logic [dpa_pkg::CHAR_BITS-1:0]  rsp_char_ff;
   logic                           rsp_last_ff;

   logic [OPERAND_BITS-1:0]        op_a;
   logic [OPERAND_BITS-1:0]        op_b;
   logic [PROD_BITS-1:0]           prod_w;
   logic                           out_free;
   logic                           emit_go;
   logic                           top_zero;
   logic                           skip_lead;
   dpa_pkg::cell_op_type           cell_op;
   logic [NUM_DIGITS-1:0]          carry_w;
   logic [DB-1:0]                  digit_w [NUM_DIGITS];

   assign op_a      = req_tdata[OPERAND_BITS-1:0];
   assign op_b      = req_tdata[dpa_pkg::FIELD_BITS +: OPERAND_BITS];
   assign prod_w    = PROD_BITS'(op_a) * PROD_BITS'(op_b);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_go   = (state_ff == ST_EMIT) && out_free;
   assign top_zero  = (digit_w[NUM_DIGITS-1] == '0);
   assign skip_lead = top_zero && (remaining_ff > REM_BITS'(1));
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      case (state_ff)
         ST_IDLE:   cell_op = req_tvalid ? dpa_pkg::CELL_CLEAR : dpa_pkg::CELL_HOLD;
         ST_DABBLE: cell_op = dpa_pkg::CELL_DABBLE;
         ST_SKIP:   cell_op = skip_lead ? dpa_pkg::CELL_SHIFT : dpa_pkg::CELL_HOLD;
         ST_EMIT:   cell_op = out_free ? dpa_pkg::CELL_SHIFT : dpa_pkg::CELL_HOLD;
         default:   cell_op = dpa_pkg::CELL_HOLD;
      endcase
   end

   // cell 0 holds the least significant digit, the top cell the most significant
   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      logic          cin;
      logic [DB-1:0] lower;
      if (i == 0) begin : g_first
         assign cin   = product_ff[PROD_BITS-1];
         assign lower = '0;
      end else begin : g_next
         assign cin   = carry_w[i-1];
         assign lower = digit_w[i-1];
      end
      dpa_cell u_cell (
         .clock       (clock),
         .op          (cell_op),
         .carry_bit   (cin),
         .lower_digit (lower),
         .carry_out   (carry_w[i]),
         .digit       (digit_w[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         remaining_ff <= '0;
      end else begin
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  product_ff <= prod_w;
                  count_ff   <= '0;
                  state_ff   <= ST_DABBLE;
               end
            end
            ST_DABBLE: begin
               product_ff <= product_ff << 1;
               count_ff   <= count_ff + CNT_BITS'(1);
               if (count_ff == CNT_BITS'(PROD_BITS - 1)) begin
                  remaining_ff <= REM_BITS'(NUM_DIGITS);
                  state_ff     <= ST_SKIP;
               end
            end
            ST_SKIP: begin
               if (skip_lead) begin
                  remaining_ff <= remaining_ff - REM_BITS'(1);
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_char_ff  <= dpa_pkg::ASCII_ZERO
                                  + {{(dpa_pkg::CHAR_BITS - DB){1'b0}}, digit_w[NUM_DIGITS-1]};
                  rsp_last_ff  <= (remaining_ff == REM_BITS'(1));
                  remaining_ff <= remaining_ff - REM_BITS'(1);
                  if (remaining_ff == REM_BITS'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - dpa_pkg::CHAR_BITS){1'b0}}, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_DABBLE))
      else $error("accepted item did not start the digit conversion");

   a_dabble_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DABBLE && count_ff == CNT_BITS'(PROD_BITS - 1))
      |=> (state_ff == ST_SKIP && remaining_ff == REM_BITS'(NUM_DIGITS)))
      else $error("conversion did not hand over with a full digit count");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_char_ff >= dpa_pkg::ASCII_ZERO
                        && rsp_char_ff <= dpa_pkg::ASCII_ZERO + 6'd9))
      else $error("emitted character is not a decimal digit");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT || state_ff == ST_SKIP)
      |-> (remaining_ff != '0 && remaining_ff <= REM_BITS'(NUM_DIGITS)))
      else $error("digit count out of range while emitting");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && remaining_ff == REM_BITS'(1))
      |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("final digit not flagged or block not back to idle");

endmodule
